### rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// shared constants, types and the half-step coil table
// ----------------------------------------------------------------------------
package hss_pkg;

    localparam int NUM_MOTORS  = 6;
    localparam int COUNT_WIDTH = 16;

    localparam int MOTOR_SLOTS = 6;
    localparam int SEL_W       = 3;
    localparam int CYCLE_W     = 16;
    localparam int PHASE_W     = 3;
    localparam int COIL_W      = 4;
    localparam int BANK_W      = 8;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = '0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = '1;

    typedef struct packed {
        logic load;
        logic tick;
    } t_chan_ctl;

    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'b1000;
            3'd1:    pat = 4'b1010;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b0101;
            3'd6:    pat = 4'b0001;
            3'd7:    pat = 4'b1001;
            default: pat = 4'b0000;
        endcase
        return pat;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [CYCLE_W-1:0] value);
        logic [COUNT_WIDTH+CYCLE_W-1:0] wide;
        wide = {{COUNT_WIDTH{1'b0}}, value};
        return wide[COUNT_WIDTH-1:0];
    endfunction

endpackage

### rtl/six_channel_half_step_sequencer.sv
// ----------------------------------------------------------------------------
// six_channel_half_step_sequencer
// half-step coil sequencer for six bipolar stepper motors
//
//   channel   valid     ready     payload
//   request   i_valid   o_ready   i_req_type i_motor_sel i_dir_cmd i_cycle_count
//   coils     o_valid   i_ready   o_coil_bank_a/b/c o_motors_active
//
// one word per cycle: input register, per-motor update logic, result register
// a tick word yields one coil word, through the input and result registers; a load yields none
// synchronous active-low reset clears all motor state and both stages
// a stalled result blocks ticks behind it; loads still pass through
// ----------------------------------------------------------------------------
module six_channel_half_step_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_req_type,
    input  logic [hss_pkg::SEL_W-1:0]        i_motor_sel,
    input  logic                             i_dir_cmd,
    input  logic [hss_pkg::CYCLE_W-1:0]      i_cycle_count,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [hss_pkg::BANK_W-1:0]       o_coil_bank_a,
    output logic [hss_pkg::BANK_W-1:0]       o_coil_bank_b,
    output logic [hss_pkg::BANK_W-1:0]       o_coil_bank_c,
    output logic [hss_pkg::MOTOR_SLOTS-1:0]  o_motors_active
);

    logic                                     r_in_valid;
    logic                                     r_in_req;
    logic [hss_pkg::SEL_W-1:0]                r_in_sel;
    logic                                     r_in_dir;
    logic [hss_pkg::COUNT_WIDTH-1:0]          r_in_count;

    logic                                     r_out_valid;
    logic [hss_pkg::BANK_W-1:0]               r_bank_a, r_bank_b, r_bank_c;
    logic [hss_pkg::MOTOR_SLOTS-1:0]          r_active;

    logic                                     w_out_free;
    logic                                     w_adv;
    logic                                     w_tick;
    logic [hss_pkg::COIL_W-1:0]               w_coil [hss_pkg::MOTOR_SLOTS];
    logic [hss_pkg::MOTOR_SLOTS-1:0]          w_active;
    logic [hss_pkg::MOTOR_SLOTS-1:0]          w_out_nz;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_adv      = r_in_valid && ((r_in_req == hss_pkg::REQ_LOAD) || w_out_free);
    assign w_tick     = w_adv && (r_in_req == hss_pkg::REQ_TICK);
    assign o_ready    = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_req   <= i_req_type;
            r_in_sel   <= i_motor_sel;
            r_in_dir   <= i_dir_cmd;
            r_in_count <= hss_pkg::fit_count(i_cycle_count);
        end
    end

    // motor channels
    for (genvar m = 0; m < hss_pkg::MOTOR_SLOTS; m++) begin : g_motor
        if (m < hss_pkg::NUM_MOTORS) begin : g_used
            hss_pkg::t_chan_ctl w_ctl;

            assign w_ctl.load = w_adv && (r_in_req == hss_pkg::REQ_LOAD)
                                && (r_in_sel == hss_pkg::SEL_W'(m));
            assign w_ctl.tick = w_tick;

            hss_chan u_chan (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_dir    (r_in_dir),
                .i_count  (r_in_count),
                .o_coil   (w_coil[m]),
                .o_active (w_active[m])
            );
        end else begin : g_absent
            assign w_coil[m]   = '0;
            assign w_active[m] = 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_bank_a <= {w_coil[1], w_coil[0]};
            r_bank_b <= {w_coil[3], w_coil[2]};
            r_bank_c <= {w_coil[5], w_coil[4]};
            r_active <= w_active;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_coil_bank_a   = r_bank_a;
    assign o_coil_bank_b   = r_bank_b;
    assign o_coil_bank_c   = r_bank_c;
    assign o_motors_active = r_active;

    assign w_out_nz = {r_bank_c[7:4] != '0, r_bank_c[3:0] != '0,
                       r_bank_b[7:4] != '0, r_bank_b[3:0] != '0,
                       r_bank_a[7:4] != '0, r_bank_a[3:0] != '0};

    a_active_matches_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_active == w_out_nz))
        else $error("active bits disagree with coil nibbles");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_in_req == hss_pkg::REQ_LOAD) && !r_out_valid) |=> !r_out_valid)
        else $error("load produced a result word");

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_out_valid)
        else $error("tick did not produce a result word");

    a_stall_blocks_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_tick)
        else $error("tick processed while result stalled");

endmodule

### rtl/hss_chan.sv
// ----------------------------------------------------------------------------
// hss_chan
// one motor channel: count, direction and phase, with coil pattern decode
// ----------------------------------------------------------------------------
module hss_chan (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hss_pkg::t_chan_ctl                  i_ctl,
    input  logic                                i_dir,
    input  logic [hss_pkg::COUNT_WIDTH-1:0]     i_count,
    output logic [hss_pkg::COIL_W-1:0]          o_coil,
    output logic                                o_active
);

    logic [hss_pkg::COUNT_WIDTH-1:0] r_count, n_count;
    logic                            r_dir, n_dir;
    logic [hss_pkg::PHASE_W-1:0]     r_phase, n_phase;
    logic                            w_wrap;

    assign o_active = (r_count != '0);
    assign o_coil   = o_active ? hss_pkg::coil_pattern(r_phase) : '0;
    assign w_wrap   = r_dir ? (r_phase == hss_pkg::PHASE_LAST)
                            : (r_phase == hss_pkg::PHASE_FIRST);

    always_comb begin
        n_count = r_count;
        n_dir   = r_dir;
        n_phase = r_phase;
        if (i_ctl.load) begin
            n_count = i_count;
            n_dir   = i_dir;
        end else if (i_ctl.tick && o_active) begin
            n_phase = r_dir ? r_phase + 1'b1 : r_phase - 1'b1;
            if (w_wrap) begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dir   <= 1'b0;
            r_phase <= '0;
        end else begin
            r_count <= n_count;
            r_dir   <= n_dir;
            r_phase <= n_phase;
        end
    end

endmodule
